>>> sv/schmitt_min_pulse_finder_macros.svh
// assertion macros used by the checker of this block
`ifndef SCHMITT_MIN_PULSE_FINDER_MACROS_SVH
`define SCHMITT_MIN_PULSE_FINDER_MACROS_SVH

// property checked on every clock edge outside reset
`define SMPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define SMPF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/smpf_pkg.sv
`timescale 1ns / 1ps

package smpf_pkg;

  // record length limit and index width
  localparam int unsigned MAX_SAMPLES = 131072;
  localparam int unsigned IDX_W       = 17;
  localparam int unsigned FIELD_MAX_INT = 131071;
  localparam int unsigned INDEX_LIMIT_INT =
    (MAX_SAMPLES - 1 < FIELD_MAX_INT) ? (MAX_SAMPLES - 1) : FIELD_MAX_INT;
  localparam logic [IDX_W-1:0] INDEX_LIMIT = IDX_W'(INDEX_LIMIT_INT);
  localparam logic [IDX_W-1:0] FIELD_MAX   = IDX_W'(FIELD_MAX_INT);

  // sample and configuration widths
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LEVEL = CFG_IDX_W'(1);

  // reset thresholds
  localparam logic [SAMPLE_W-1:0] LOW_LEVEL_RST  = SAMPLE_W'(112);
  localparam logic [SAMPLE_W-1:0] HIGH_LEVEL_RST = SAMPLE_W'(144);

  // schmitt trigger state, one-hot
  typedef enum logic [2:0] {
    TRIG_LOW     = 3'b001,
    TRIG_HIGH    = 3'b010,
    TRIG_UNKNOWN = 3'b100
  } trig_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] low_level;
    logic [SAMPLE_W-1:0] high_level;
  } thresh_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] center_index;
    logic [IDX_W-1:0] pulse_width;
    logic             pulse_high;
    logic [IDX_W-1:0] pulse_count;
  } result_t;

endpackage

>>> sv/smpf_in_if.sv
`timescale 1ns / 1ps

// sample stream
interface smpf_in_if;
  logic                          valid;
  logic                          ready;
  logic [smpf_pkg::SAMPLE_W-1:0] sample;
  logic                          last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

>>> sv/smpf_out_if.sv
`timescale 1ns / 1ps

// per-record result stream
interface smpf_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [smpf_pkg::IDX_W-1:0] center_index;
  logic [smpf_pkg::IDX_W-1:0] pulse_width;
  logic                       pulse_high;
  logic [smpf_pkg::IDX_W-1:0] pulse_count;

  modport source (output valid, output found, output center_index, output pulse_width,
                  output pulse_high, output pulse_count, input ready);
  modport sink (input valid, input found, input center_index, input pulse_width,
                input pulse_high, input pulse_count, output ready);
endinterface

>>> sv/smpf_cfg_if.sv
`timescale 1ns / 1ps

// register write channel
interface smpf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [smpf_pkg::CFG_IDX_W-1:0] index;
  logic [smpf_pkg::CFG_DAT_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> sv/smpf_cfg_regs.sv
`timescale 1ns / 1ps

module smpf_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  smpf_cfg_if.sink          cfg,
  output smpf_pkg::thresh_t thresh
);

  smpf_pkg::thresh_t thresh_r;

  // writes are always taken
  assign cfg.ready = 1'b1;
  assign thresh    = thresh_r;

  // threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r.low_level  <= smpf_pkg::LOW_LEVEL_RST;
      thresh_r.high_level <= smpf_pkg::HIGH_LEVEL_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        smpf_pkg::CFG_LOW_LEVEL:  thresh_r.low_level  <= cfg.wdata[smpf_pkg::SAMPLE_W-1:0];
        smpf_pkg::CFG_HIGH_LEVEL: thresh_r.high_level <= cfg.wdata[smpf_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/smpf_run_tracker.sv
`timescale 1ns / 1ps

module smpf_run_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic [smpf_pkg::SAMPLE_W-1:0] sample,
  input  logic                          last_sample,
  input  smpf_pkg::thresh_t             thresh,
  output smpf_pkg::result_t             res
);

  localparam int unsigned W = smpf_pkg::IDX_W;

  smpf_pkg::trig_t trig_r, trig_nxt, trig_new;
  logic [W-1:0]    start_r, start_nxt;
  logic            start_valid_r, start_valid_nxt;
  logic [W-1:0]    idx_r, idx_nxt;
  logic [W-1:0]    best_width_r, best_width_nxt, bw_post;
  logic [W-1:0]    best_center_r, best_center_nxt, bc_post;
  logic            best_valid_r, best_valid_nxt, bv_post;
  logic            best_pol_r, best_pol_nxt, bh_post;
  logic [W-1:0]    match_cnt_r, match_cnt_nxt, bn_post;

  logic         changed, known, close_run, was_high, better, tie;
  logic [W-1:0] w;

  // schmitt classification, high wins when the levels cross
  always_comb begin
    trig_new = trig_r;
    if (sample > thresh.high_level) begin
      trig_new = smpf_pkg::TRIG_HIGH;
    end else if (sample < thresh.low_level) begin
      trig_new = smpf_pkg::TRIG_LOW;
    end
  end

  // run closing and narrowest-run update
  always_comb begin
    changed   = (trig_new != trig_r);
    known     = (trig_r != smpf_pkg::TRIG_UNKNOWN);
    was_high  = (trig_r == smpf_pkg::TRIG_HIGH);
    close_run = changed && known && start_valid_r;
    w         = idx_r - start_r;
    better    = !best_valid_r || (w < best_width_r);
    tie       = (w == best_width_r) && (was_high == best_pol_r);

    bw_post = best_width_r;
    bc_post = best_center_r;
    bv_post = best_valid_r;
    bh_post = best_pol_r;
    bn_post = match_cnt_r;
    if (close_run) begin
      if (better) begin
        bw_post = w;
        bc_post = start_r + (w >> 1);
        bh_post = was_high;
        bn_post = W'(1);
        bv_post = 1'b1;
      end else if (tie && (match_cnt_r < smpf_pkg::FIELD_MAX)) begin
        bn_post = match_cnt_r + W'(1);
      end
    end
  end

  // result of the record as it stands after this sample
  assign res.found        = bv_post;
  assign res.center_index = bc_post;
  assign res.pulse_width  = bw_post;
  assign res.pulse_high   = bh_post;
  assign res.pulse_count  = bn_post;

  // next state, cleared at the end of a record
  always_comb begin
    trig_nxt        = trig_r;
    start_nxt       = start_r;
    start_valid_nxt = start_valid_r;
    idx_nxt         = idx_r;
    best_width_nxt  = best_width_r;
    best_center_nxt = best_center_r;
    best_valid_nxt  = best_valid_r;
    best_pol_nxt    = best_pol_r;
    match_cnt_nxt   = match_cnt_r;
    if (step_en) begin
      if (last_sample) begin
        trig_nxt        = smpf_pkg::TRIG_UNKNOWN;
        start_nxt       = '0;
        start_valid_nxt = 1'b0;
        idx_nxt         = '0;
        best_width_nxt  = '0;
        best_center_nxt = '0;
        best_valid_nxt  = 1'b0;
        best_pol_nxt    = 1'b0;
        match_cnt_nxt   = '0;
      end else begin
        if (changed) begin
          trig_nxt        = trig_new;
          start_nxt       = idx_r;
          start_valid_nxt = known;
        end
        if (idx_r < smpf_pkg::INDEX_LIMIT) begin
          idx_nxt = idx_r + W'(1);
        end
        best_width_nxt  = bw_post;
        best_center_nxt = bc_post;
        best_valid_nxt  = bv_post;
        best_pol_nxt    = bh_post;
        match_cnt_nxt   = bn_post;
      end
    end
  end

  // per-record state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r        <= smpf_pkg::TRIG_UNKNOWN;
      start_r       <= '0;
      start_valid_r <= 1'b0;
      idx_r         <= '0;
      best_width_r  <= '0;
      best_center_r <= '0;
      best_valid_r  <= 1'b0;
      best_pol_r    <= 1'b0;
      match_cnt_r   <= '0;
    end else begin
      trig_r        <= trig_nxt;
      start_r       <= start_nxt;
      start_valid_r <= start_valid_nxt;
      idx_r         <= idx_nxt;
      best_width_r  <= best_width_nxt;
      best_center_r <= best_center_nxt;
      best_valid_r  <= best_valid_nxt;
      best_pol_r    <= best_pol_nxt;
      match_cnt_r   <= match_cnt_nxt;
    end
  end

endmodule

>>> sv/schmitt_min_pulse_finder.sv
`timescale 1ns / 1ps

// Narrowest complete pulse finder: one 8-bit sample per transaction, in time order, with
// last_sample marking the end of a record. Samples pass a Schmitt trigger set by low_level
// and high_level (register 0 and 1); runs bounded by transitions on both sides are
// measured and the narrowest one (earliest on a tie) is reported with its centre, polarity
// and the number of equal runs, as one result per record. The block takes one sample every
// clock while its input side does not stall: a sample lands in an input register, and the
// tracker handles it from there in the step that, for a record's last sample, also loads
// the result register. The output register holds a result until taken; the input side
// only stalls when a record ends while the previous record's result still waits there.
// Sample indexes saturate at 131071.
module schmitt_min_pulse_finder (
  input  logic        clk,
  input  logic        rst_n,
  smpf_in_if.sink     in_ch,
  smpf_out_if.source  out_ch,
  smpf_cfg_if.sink    cfg_ch
);

  smpf_pkg::thresh_t thresh;
  smpf_pkg::result_t res;

  logic                          stg_valid_r;
  logic [smpf_pkg::SAMPLE_W-1:0] stg_sample_r;
  logic                          stg_last_r;
  logic                          stg_go, step_en, in_take;

  logic              out_valid_r;
  smpf_pkg::result_t out_res_r;

  // stage advance: only a record end needs a free output register
  assign stg_go      = !stg_last_r || !out_valid_r || out_ch.ready;
  assign step_en     = stg_valid_r && stg_go;
  assign in_ch.ready = !stg_valid_r || stg_go;
  assign in_take     = in_ch.valid && in_ch.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_take) begin
      stg_valid_r <= 1'b1;
    end else if (step_en) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_sample_r <= in_ch.sample;
      stg_last_r   <= in_ch.last_sample;
    end
  end

  smpf_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_ch),
    .thresh (thresh)
  );

  smpf_run_tracker u_trk (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .sample      (stg_sample_r),
    .last_sample (stg_last_r),
    .thresh      (thresh),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en && stg_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && stg_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_res_r.found;
  assign out_ch.center_index = out_res_r.center_index;
  assign out_ch.pulse_width  = out_res_r.pulse_width;
  assign out_ch.pulse_high   = out_res_r.pulse_high;
  assign out_ch.pulse_count  = out_res_r.pulse_count;

endmodule

>>> sv/smpf_checker.sv
`timescale 1ns / 1ps
`include "schmitt_min_pulse_finder_macros.svh"

module smpf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_found,
  input logic [smpf_pkg::IDX_W-1:0] out_center_index,
  input logic [smpf_pkg::IDX_W-1:0] out_pulse_width,
  input logic                       out_pulse_high,
  input logic [smpf_pkg::IDX_W-1:0] out_pulse_count
);

  logic fields_zero;

  // every field beside found is zero
  assign fields_zero = (out_center_index == '0) && (out_pulse_width == '0) &&
                       !out_pulse_high && (out_pulse_count == '0);

  // a pending result stays until taken
  `SMPF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // an empty record reports all zeros
  `SMPF_ASSERT(a_empty_zero, out_valid && !out_found |-> fields_zero, "empty record with nonzero fields")

  // a found pulse counts at least itself
  `SMPF_ASSERT(a_count_nonzero, out_valid && out_found |-> out_pulse_count != '0, "found pulse with zero count")

  // register writes never stall
  `SMPF_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "register write stalled")

  // nothing comes out right after reset
  `SMPF_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind schmitt_min_pulse_finder smpf_checker u_smpf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .cfg_valid        (cfg_ch.valid),
  .cfg_ready        (cfg_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_found        (out_ch.found),
  .out_center_index (out_ch.center_index),
  .out_pulse_width  (out_ch.pulse_width),
  .out_pulse_high   (out_ch.pulse_high),
  .out_pulse_count  (out_ch.pulse_count)
);

>>> tb/schmitt_min_pulse_finder_tb.sv
`timescale 1ns / 1ps

module schmitt_min_pulse_finder_tb;
  import smpf_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_ITEMS   = 125;

  // narrowest pulse tracker: mirrors the block's per-record state and
  // keeps the results still owed by the block, oldest first
  class pulse_tracker;
    logic [SAMPLE_W-1:0] low_level;
    logic [SAMPLE_W-1:0] high_level;
    trig_t               trig;
    logic [IDX_W-1:0]    open_start;
    bit                  run_open;
    logic [IDX_W-1:0]    idx;
    logic [IDX_W-1:0]    best_width;
    logic [IDX_W-1:0]    best_center;
    bit                  best_valid;
    bit                  best_pol;
    logic [IDX_W-1:0]    match_cnt;
    result_t             pending_results[$];
    int unsigned         errors;
    int unsigned         samples;
    int unsigned         records;
    int unsigned         found_records;

    function new();
      low_level  = LOW_LEVEL_RST;
      high_level = HIGH_LEVEL_RST;
      clear_record();
    endfunction

    function void clear_record();
      trig        = TRIG_UNKNOWN;
      open_start  = '0;
      run_open    = 1'b0;
      idx         = '0;
      best_width  = '0;
      best_center = '0;
      best_valid  = 1'b0;
      best_pol    = 1'b0;
      match_cnt   = '0;
    endfunction

    function void set_level(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] value);
      case (index)
        CFG_LOW_LEVEL:  low_level = value;
        CFG_HIGH_LEVEL: high_level = value;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // one accepted sample transaction
    function void take_sample(logic [SAMPLE_W-1:0] s, logic last);
      trig_t            nxt;
      logic [IDX_W-1:0] now;
      logic [IDX_W-1:0] w;
      result_t          res;
      nxt = trig;
      now = idx;
      samples++;
      if (s > high_level) nxt = TRIG_HIGH;
      else if (s < low_level) nxt = TRIG_LOW;

      // a transition closes the current run if it had a known start edge
      if (nxt != trig) begin
        if (trig != TRIG_UNKNOWN && run_open) begin
          w = now - open_start;
          if (!best_valid || w < best_width) begin
            best_width  = w;
            best_center = open_start + (w >> 1);
            best_pol    = (trig == TRIG_HIGH);
            match_cnt   = IDX_W'(1);
            best_valid  = 1'b1;
          end else if (w == best_width && (trig == TRIG_HIGH) == best_pol) begin
            if (match_cnt < FIELD_MAX) match_cnt = match_cnt + 1'b1;
          end
        end
        run_open   = (trig != TRIG_UNKNOWN);
        open_start = now;
        trig       = nxt;
      end

      if (!last) begin
        if (idx < INDEX_LIMIT) idx = idx + 1'b1;
        return;
      end

      // end of record: one result, then a fresh record
      res = '0;
      if (best_valid) begin
        res.found        = 1'b1;
        res.center_index = best_center;
        res.pulse_width  = best_width;
        res.pulse_high   = best_pol;
        res.pulse_count  = match_cnt;
        found_records++;
      end
      pending_results.push_back(res);
      records++;
      clear_record();
    endfunction

    // one accepted result transaction
    function void compare_result(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        $error("result with no record pending: found=%0d width=%0d", got.found,
               got.pulse_width);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.found !== exp.found) begin
        $error("found: expected %0d, actual %0d", exp.found, got.found);
        errors++;
      end
      if (got.center_index !== exp.center_index) begin
        $error("center_index: expected %0d, actual %0d", exp.center_index,
               got.center_index);
        errors++;
      end
      if (got.pulse_width !== exp.pulse_width) begin
        $error("pulse_width: expected %0d, actual %0d", exp.pulse_width, got.pulse_width);
        errors++;
      end
      if (got.pulse_high !== exp.pulse_high) begin
        $error("pulse_high: expected %0d, actual %0d", exp.pulse_high, got.pulse_high);
        errors++;
      end
      if (got.pulse_count !== exp.pulse_count) begin
        $error("pulse_count: expected %0d, actual %0d", exp.pulse_count, got.pulse_count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  smpf_in_if  in_ch();
  smpf_out_if out_ch();
  smpf_cfg_if cfg_ch();

  pulse_tracker tracker;
  int unsigned  in_idle_pct;
  int unsigned  out_stall_pct;
  int unsigned  hold_reqs = 0;
  int unsigned  hold_seen = 0;
  int unsigned  hold_left = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  settings;

  schmitt_min_pulse_finder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side ready, with random stalls and one long hold-off
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.compare_result('{found: out_ch.found, center_index: out_ch.center_index,
                               pulse_width: out_ch.pulse_width, pulse_high: out_ch.pulse_high,
                               pulse_count: out_ch.pulse_count});
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $error("no transaction for %0d cycles, %0d results outstanding", QUIET_LIMIT,
             tracker.pending());
      $display("schmitt_min_pulse_finder_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one sample transaction, after a random idle gap
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= s;
    in_ch.last_sample <= last;
    do @(posedge clk); while (!in_ch.ready);
    tracker.take_sample(s, last);
  endtask

  // stop sending and wait for every owed result, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both thresholds, back to back on the write channel
  task automatic write_levels(input logic [CFG_DAT_W-1:0] lo, input logic [CFG_DAT_W-1:0] hi);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_LOW_LEVEL;
    cfg_ch.wdata <= lo;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.set_level(CFG_LOW_LEVEL, lo);
    cfg_ch.index <= CFG_HIGH_LEVEL;
    cfg_ch.wdata <= hi;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.set_level(CFG_HIGH_LEVEL, hi);
    cfg_ch.valid <= 1'b0;
    settings++;
  endtask

  // record of alternating runs with random lengths, mostly clean levels plus noise
  task automatic send_random_record(input int unsigned max_len);
    int unsigned         len;
    int unsigned         run_left;
    bit                  hi_run;
    logic [SAMPLE_W-1:0] s;
    len      = $urandom_range(max_len, 1);
    hi_run   = $urandom_range(1);
    run_left = 0;
    for (int unsigned i = 0; i < len; i++) begin
      if (run_left == 0) begin
        hi_run   = !hi_run;
        run_left = $urandom_range(6, 1);
      end
      run_left--;
      if ($urandom_range(9) < 2) s = SAMPLE_W'($urandom_range(255));
      else if (hi_run && tracker.high_level < 8'd255)
        s = SAMPLE_W'($urandom_range(255, tracker.high_level + 1));
      else if (!hi_run && tracker.low_level > 8'd0)
        s = SAMPLE_W'($urandom_range(tracker.low_level - 1, 0));
      else s = SAMPLE_W'($urandom_range(255));
      send_sample(s, i == len - 1);
    end
  endtask

  initial begin
    int unsigned lo;
    int unsigned hi;
    int unsigned phase_start;
    tracker = new();
    in_idle_pct        = 0;
    out_stall_pct      = 0;
    settings           = 0;
    in_ch.valid        = 1'b0;
    in_ch.sample       = '0;
    in_ch.last_sample  = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.wdata       = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: lone sample with the trigger never decided
    send_sample(8'd128, 1'b1);
    // one-sample pulses of both polarities at the sample extremes
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b1);
    // samples sitting exactly on the thresholds hold the state
    send_sample(8'd255, 1'b0);
    send_sample(8'd112, 1'b0);
    send_sample(8'd144, 1'b0);
    send_sample(8'd111, 1'b0);
    send_sample(8'd113, 1'b0);
    send_sample(8'd145, 1'b0);
    send_sample(8'd144, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd200, 1'b1);
    drain();

    // crossed thresholds: a sample both above high and below low reads high
    write_levels(8'd200, 8'd50);
    send_sample(8'd100, 1'b0);
    send_sample(8'd30, 1'b0);
    send_sample(8'd220, 1'b0);
    send_sample(8'd100, 1'b0);
    send_sample(8'd40, 1'b1);
    drain();

    // widest band: no sample is ever decisive
    write_levels(8'd0, 8'd255);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b1);
    drain();

    // fully crossed: only zero reads low
    write_levels(8'd255, 8'd0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd5, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd9, 1'b0);
    send_sample(8'd0, 1'b1);
    drain();

    // random phases with different idling and thresholds
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct   = 88;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 88;
        end
        default: begin
          in_idle_pct   = 16;
          out_stall_pct = 16;
        end
      endcase
      lo = $urandom_range(150, 20);
      hi = lo + $urandom_range(100, 0);
      write_levels(lo[CFG_DAT_W-1:0], hi[CFG_DAT_W-1:0]);

      phase_start = tracker.samples;
      while (tracker.samples - phase_start < PHASE_ITEMS / 2) send_random_record(12);

      // receiver held off while short records keep coming, so the input stalls
      if (p == 0) begin
        hold_reqs++;
        for (int r = 0; r < 30; r++) send_random_record(3);
      end
      // sender pauses until the block has delivered everything
      if (p == 1) drain();

      while (tracker.samples - phase_start < PHASE_ITEMS) send_random_record(12);
      drain();
    end

    $display("covered %0d samples in %0d records (%0d with a pulse) over %0d threshold settings",
             tracker.samples, tracker.records, tracker.found_records, settings);
    $display("four idling phases, one long receiver hold-off and one mid-phase drain");
    if (tracker.errors == 0) begin
      $display("schmitt_min_pulse_finder_tb: done, clean");
    end else begin
      $display("schmitt_min_pulse_finder_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> schmitt_min_pulse_finder.f
+incdir+sv
sv/smpf_pkg.sv
sv/smpf_in_if.sv
sv/smpf_out_if.sv
sv/smpf_cfg_if.sv
sv/smpf_cfg_regs.sv
sv/smpf_run_tracker.sv
sv/schmitt_min_pulse_finder.sv
sv/smpf_checker.sv
tb/schmitt_min_pulse_finder_tb.sv
